[sv/set_assoc_lru_cache_lookup_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative LRU cache lookup core
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_CORE_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_CORE_DEFINES_SVH

// same-cycle implication
`define SALC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("salc: property violated");

// next-cycle implication
`define SALC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("salc: property violated");

`endif

[sv/salc_pkg.sv]
// ----------------------------------------------------------------------------
// salc_pkg
// Types and fixed widths of the set-associative LRU cache lookup core.
// ----------------------------------------------------------------------------
`default_nettype none

package salc_pkg;

    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 62;
    localparam int STAMP_W    = 64;
    localparam int OUTCOME_W  = 2;
    localparam int WAY_OUT_W  = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int SET_CFG_W  = 4;
    localparam int OFF_CFG_W  = 5;
    localparam int WAYS_CFG_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 8'd2;

    localparam logic [SET_CFG_W-1:0]  SET_BITS_RST    = 4'd4;
    localparam logic [OFF_CFG_W-1:0]  OFFSET_BITS_RST = 5'd4;
    localparam logic [WAYS_CFG_W-1:0] WAYS_RST        = 4'd8;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_MISS  = 2'd0,
        OUT_HIT   = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MATCH,
        ST_SCAN,
        ST_WRITE
    } t_state;

endpackage

`default_nettype wire

[sv/salc_req_if.sv]
// ----------------------------------------------------------------------------
// salc_req_if
// Request channel: one address per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface salc_req_if;
    logic                        valid;
    logic                        ready;
    logic [salc_pkg::ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

`default_nettype wire

[sv/salc_rsp_if.sv]
// ----------------------------------------------------------------------------
// salc_rsp_if
// Response channel: lookup outcome and way.
// ----------------------------------------------------------------------------
`default_nettype none

interface salc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [salc_pkg::OUTCOME_W-1:0] outcome;
    logic [salc_pkg::WAY_OUT_W-1:0] way;

    modport source (output valid, output outcome, output way, input ready);
    modport sink   (input valid, input outcome, input way, output ready);
endinterface

`default_nettype wire

[sv/salc_cfg_if.sv]
// ----------------------------------------------------------------------------
// salc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface salc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [salc_pkg::CFG_IDX_W-1:0]  index;
    logic [salc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/salc_row_ram.sv]
// ----------------------------------------------------------------------------
// salc_row_ram
// One-port-write, one-port-read set memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_row_ram #(
    parameter int ADDR_BITS = 8,
    parameter int WIDTH     = 1016
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[sv/salc_match.sv]
// ----------------------------------------------------------------------------
// salc_match
// Parallel tag compare and first-hit / first-empty way selection of one set.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_match #(
    parameter int MAX_WAYS = 8,
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int NW_W    = $clog2(MAX_WAYS + 1),
    localparam int ROW_W   = MAX_WAYS * (1 + salc_pkg::TAG_W + salc_pkg::STAMP_W)
) (
    input  logic [ROW_W-1:0]           i_row,
    input  logic [salc_pkg::TAG_W-1:0] i_tag,
    input  logic [NW_W-1:0]            i_ways,
    output logic                       o_hit,
    output logic [WAY_W-1:0]           o_hit_way,
    output logic                       o_empty,
    output logic [WAY_W-1:0]           o_empty_way
);

    typedef struct packed {
        logic [MAX_WAYS-1:0]                          valid;
        logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]     tag;
        logic [MAX_WAYS-1:0][salc_pkg::STAMP_W-1:0]   stamp;
    } t_row;

    t_row row;

    assign row = t_row'(i_row);

    // scan downward so the lowest qualifying way wins
    always_comb begin
        o_hit       = 1'b0;
        o_hit_way   = '0;
        o_empty     = 1'b0;
        o_empty_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (NW_W'(w) < i_ways) begin
                if (row.valid[w] && (row.tag[w] == i_tag)) begin
                    o_hit     = 1'b1;
                    o_hit_way = WAY_W'(w);
                end
                if (!row.valid[w]) begin
                    o_empty     = 1'b1;
                    o_empty_way = WAY_W'(w);
                end
            end
        end
    end

endmodule

`default_nettype wire

[sv/set_assoc_lru_cache_lookup_core.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_core
// Tag store of a set-associative cache with LRU replacement.
// ----------------------------------------------------------------------------
// One request at a time. A hit or a fill of an empty way holds the request side
// through row read, compare and write back, and registers its response with
// the write back; an eviction adds a stamp scan over the ways in use, with
// ways_in_use taken after clamping to 1..MAX_WAYS. The response register frees
// the request side: the next request is taken while the last response still
// waits, and only its write back waits for the register to drain. After reset
// a clearing pass over all 2^MAX_SET_BITS rows zeroes the set memory, one row
// a cycle, with no request accepted; configuration writes are taken
// throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_lookup_core #(
    parameter int MAX_WAYS     = 8,
    parameter int MAX_SET_BITS = 8,
    parameter int ADDR_BITS    = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    salc_req_if.sink  i_req,
    salc_rsp_if.source o_rsp,
    salc_cfg_if.sink  i_cfg
);

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W  = $clog2(MAX_WAYS + 1);
    localparam int SET_W = MAX_SET_BITS;
    localparam int ROW_W = MAX_WAYS * (1 + salc_pkg::TAG_W + salc_pkg::STAMP_W);
    localparam logic [salc_pkg::ADDR_W-1:0] ADDR_MASK =
        {salc_pkg::ADDR_W{1'b1}} >> (salc_pkg::ADDR_W - ADDR_BITS);

    typedef struct packed {
        logic [MAX_WAYS-1:0]                          valid;
        logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]     tag;
        logic [MAX_WAYS-1:0][salc_pkg::STAMP_W-1:0]   stamp;
    } t_row;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic             empty;
        logic [WAY_W-1:0] empty_way;
    } t_match;

    salc_pkg::t_state r_state, n_state;
    logic [SET_W-1:0] r_clr_addr, n_clr_addr;
    logic [salc_pkg::SET_CFG_W-1:0]  r_set_bits, n_set_bits;
    logic [salc_pkg::OFF_CFG_W-1:0]  r_offset_bits, n_offset_bits;
    logic [salc_pkg::WAYS_CFG_W-1:0] r_ways, n_ways;
    logic [salc_pkg::STAMP_W-1:0]    r_use_clock, n_use_clock;
    logic r_out_valid, n_out_valid;

    salc_pkg::t_outcome r_outcome, n_outcome;
    logic [WAY_W-1:0] r_way, n_way;
    logic [SET_W-1:0] r_set, n_set;
    logic [salc_pkg::TAG_W-1:0] r_tag, n_tag;
    t_match r_match, n_match;
    logic [WAY_W-1:0] r_scan, n_scan;
    logic [salc_pkg::STAMP_W-1:0] r_oldest, n_oldest;
    logic [WAY_W-1:0] r_lru, n_lru;

    logic [salc_pkg::SET_CFG_W-1:0] sb_eff;
    logic [salc_pkg::OFF_CFG_W-1:0] ob_eff;
    logic [salc_pkg::OFF_CFG_W:0]   ways_ext;
    logic [NW_W-1:0] nw_eff;
    logic [5:0] tag_shift;
    logic [salc_pkg::ADDR_W-1:0] addr_m;
    logic [salc_pkg::ADDR_W-1:0] addr_sh;
    logic [SET_W-1:0] set_mask;
    logic [SET_W-1:0] req_set;
    logic [salc_pkg::TAG_W-1:0] req_tag;

    logic rd_en, wr_en;
    logic [SET_W-1:0] wr_addr;
    logic [ROW_W-1:0] wr_data, rd_data;
    t_row row_q, row_upd;
    t_match match;
    logic [WAY_W-1:0] chosen;
    logic slot_free;

    salc_row_ram #(
        .ADDR_BITS (SET_W),
        .WIDTH     (ROW_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (req_set),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    salc_match #(
        .MAX_WAYS (MAX_WAYS)
    ) u_match (
        .i_row       (rd_data),
        .i_tag       (r_tag),
        .i_ways      (nw_eff),
        .o_hit       (match.hit),
        .o_hit_way   (match.hit_way),
        .o_empty     (match.empty),
        .o_empty_way (match.empty_way)
    );

    assign row_q = t_row'(rd_data);

    always_comb begin
        if (r_set_bits == '0) begin
            sb_eff = 4'd1;
        end else if (r_set_bits > salc_pkg::SET_CFG_W'(MAX_SET_BITS)) begin
            sb_eff = salc_pkg::SET_CFG_W'(MAX_SET_BITS);
        end else begin
            sb_eff = r_set_bits;
        end
        ob_eff   = (r_offset_bits == '0) ? 5'd1 : r_offset_bits;
        ways_ext = {2'b00, r_ways};
        if (ways_ext == '0) begin
            nw_eff = NW_W'(1);
        end else if (ways_ext > 6'(MAX_WAYS)) begin
            nw_eff = NW_W'(MAX_WAYS);
        end else begin
            nw_eff = NW_W'(ways_ext);
        end
    end

    assign addr_m    = i_req.address & ADDR_MASK;
    assign tag_shift = {2'b00, sb_eff} + {1'b0, ob_eff};
    assign addr_sh   = addr_m >> tag_shift;
    assign req_tag   = addr_sh[salc_pkg::TAG_W-1:0];
    assign set_mask  = ~({SET_W{1'b1}} << sb_eff);
    assign req_set   = SET_W'(addr_m >> ob_eff) & set_mask;

    assign slot_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        if (r_match.hit) begin
            chosen = r_match.hit_way;
        end else if (r_match.empty) begin
            chosen = r_match.empty_way;
        end else begin
            chosen = r_lru;
        end
        row_upd = row_q;
        row_upd.stamp[chosen] = r_use_clock + 1'b1;
        if (!r_match.hit) begin
            row_upd.valid[chosen] = 1'b1;
            row_upd.tag[chosen]   = r_tag;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_set_bits    = r_set_bits;
        n_offset_bits = r_offset_bits;
        n_ways        = r_ways;
        n_use_clock   = r_use_clock;
        n_out_valid   = r_out_valid;
        n_outcome     = r_outcome;
        n_way         = r_way;
        n_set         = r_set;
        n_tag         = r_tag;
        n_match       = r_match;
        n_scan        = r_scan;
        n_oldest      = r_oldest;
        n_lru         = r_lru;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = r_set;
        wr_data       = ROW_W'(row_upd);

        if (i_cfg.valid) begin
            case (i_cfg.index)
                salc_pkg::CFG_SET_BITS: begin
                    n_set_bits = i_cfg.data[salc_pkg::SET_CFG_W-1:0];
                end
                salc_pkg::CFG_OFFSET_BITS: begin
                    n_offset_bits = i_cfg.data[salc_pkg::OFF_CFG_W-1:0];
                end
                salc_pkg::CFG_WAYS_IN_USE: begin
                    n_ways = i_cfg.data[salc_pkg::WAYS_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            salc_pkg::ST_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                wr_data    = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == {SET_W{1'b1}}) begin
                    n_state = salc_pkg::ST_IDLE;
                end
            end
            salc_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    rd_en   = 1'b1;
                    n_set   = req_set;
                    n_tag   = req_tag;
                    n_state = salc_pkg::ST_MATCH;
                end
            end
            salc_pkg::ST_MATCH: begin
                n_match = match;
                if (match.hit || match.empty) begin
                    n_state = salc_pkg::ST_WRITE;
                end else begin
                    n_scan   = '0;
                    n_oldest = '1;
                    n_lru    = '0;
                    n_state  = salc_pkg::ST_SCAN;
                end
            end
            salc_pkg::ST_SCAN: begin
                if (row_q.stamp[r_scan] < r_oldest) begin
                    n_oldest = row_q.stamp[r_scan];
                    n_lru    = r_scan;
                end
                if (NW_W'(r_scan) == (nw_eff - 1'b1)) begin
                    n_state = salc_pkg::ST_WRITE;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            salc_pkg::ST_WRITE: begin
                if (slot_free) begin
                    wr_en       = 1'b1;
                    n_use_clock = r_use_clock + 1'b1;
                    n_out_valid = 1'b1;
                    n_way       = chosen;
                    if (r_match.hit) begin
                        n_outcome = salc_pkg::OUT_HIT;
                    end else if (r_match.empty) begin
                        n_outcome = salc_pkg::OUT_MISS;
                    end else begin
                        n_outcome = salc_pkg::OUT_EVICT;
                    end
                    n_state = salc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = salc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= salc_pkg::ST_CLEAR;
            r_clr_addr    <= '0;
            r_set_bits    <= salc_pkg::SET_BITS_RST;
            r_offset_bits <= salc_pkg::OFFSET_BITS_RST;
            r_ways        <= salc_pkg::WAYS_RST;
            r_use_clock   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr_addr    <= n_clr_addr;
            r_set_bits    <= n_set_bits;
            r_offset_bits <= n_offset_bits;
            r_ways        <= n_ways;
            r_use_clock   <= n_use_clock;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_outcome <= n_outcome;
        r_way     <= n_way;
        r_set     <= n_set;
        r_tag     <= n_tag;
        r_match   <= n_match;
        r_scan    <= n_scan;
        r_oldest  <= n_oldest;
        r_lru     <= n_lru;
    end

    assign i_req.ready   = (r_state == salc_pkg::ST_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.outcome = r_outcome;
    assign o_rsp.way     = salc_pkg::WAY_OUT_W'(r_way);

endmodule

`default_nettype wire

[sv/salc_checker.sv]
// ----------------------------------------------------------------------------
// salc_checker
// Port-level properties of the cache lookup core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "set_assoc_lru_cache_lookup_core_defines.svh"

module salc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_req_valid,
    input wire logic                           i_req_ready,
    input wire logic                           i_rsp_valid,
    input wire logic                           i_rsp_ready,
    input wire logic [salc_pkg::OUTCOME_W-1:0] i_outcome,
    input wire logic [salc_pkg::WAY_OUT_W-1:0] i_way
);

    // hold a stalled response
    `SALC_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_outcome) && $stable(i_way))

    // legal outcome codes only
    `SALC_ASSERT_IMP(a_outcome_legal, i_clk, i_rst_n, i_rsp_valid, i_outcome == salc_pkg::OUT_MISS || i_outcome == salc_pkg::OUT_HIT || i_outcome == salc_pkg::OUT_EVICT)

    // one request in flight: ready drops after an accept
    `SALC_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // clearing pass blocks requests right after reset
    `SALC_ASSERT_IMP(a_clear_blocks, i_clk, i_rst_n, !$past(i_rst_n), !i_req_ready)

endmodule

bind set_assoc_lru_cache_lookup_core salc_checker u_salc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_outcome   (o_rsp.outcome),
    .i_way       (o_rsp.way)
);

`default_nettype wire
